FILE: rtl/core/tes_pkg.sv
// Shared types and constants for the text encoding sniffer.
`default_nettype none
package tes_pkg;

    localparam logic [2:0] CLASS_UTF8_BOM  = 3'd0;
    localparam logic [2:0] CLASS_UTF16LE   = 3'd1;
    localparam logic [2:0] CLASS_UTF16BE   = 3'd2;
    localparam logic [2:0] CLASS_UTF8      = 3'd3;
    localparam logic [2:0] CLASS_LEGACY    = 3'd4;

    localparam logic [1:0] OFFSET_UTF8_BOM  = 2'd3;
    localparam logic [1:0] OFFSET_UTF16_BOM = 2'd2;
    localparam logic [1:0] OFFSET_NONE      = 2'd0;

    localparam logic [7:0] BOM8_B0   = 8'hEF;
    localparam logic [7:0] BOM8_B1   = 8'hBB;
    localparam logic [7:0] BOM8_B2   = 8'hBF;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_FE   = 8'hFE;

    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] encoding_class;
        logic [1:0] payload_offset;
    } out_beat_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tes_in_if.sv
// Input byte channel: valid, ready and one document byte per beat.
`default_nettype none
interface tes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tes_out_if.sv
// Result channel: valid, ready and one classification per beat.
`default_nettype none
interface tes_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding_class;
    logic [1:0] payload_offset;

    modport source (output valid, output encoding_class, output payload_offset, input ready);
    modport sink   (input valid, input encoding_class, input payload_offset, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tes_in_stage.sv
// Input register that captures one byte beat from the document channel.
`default_nettype none
module tes_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tes_in_if.sink                    doc,
    input  wire logic                 take,
    output tes_pkg::stage_stat_t      stat,
    output tes_pkg::in_beat_t         beat
);

    logic              valid_reg;
    logic              valid_next;
    tes_pkg::in_beat_t beat_reg;

    assign doc.ready  = !valid_reg || take;
    assign valid_next = doc.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (doc.valid && doc.ready)
        begin
            beat_reg.data_byte <= doc.data_byte;
            beat_reg.last_byte <= doc.last_byte;
        end
    end

    assign stat.valid = valid_reg;
    assign stat.last  = beat_reg.last_byte;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tes_scan.sv
// Document state, UTF-8 check and mark classification for one byte.
`default_nettype none
module tes_scan (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire tes_pkg::in_beat_t  beat,
    output tes_pkg::out_beat_t      result
);

    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [23:0] head_reg;
    logic [23:0] head_next;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic        invalid_reg;
    logic        invalid_next;

    logic [1:0]  pos_upd;
    logic [23:0] head_upd;
    logic [1:0]  pend_upd;
    logic        invalid_upd;
    logic [7:0]  b;
    logic        is_cont;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [7:0]  h2;

    assign b       = beat.data_byte;
    assign is_cont = (b[7:6] == 2'b10);

    always_comb
    begin
        head_upd = head_reg;
        pos_upd  = pos_reg;
        case (pos_reg)
            2'd0:
            begin
                head_upd[7:0] = head_reg[7:0] | b;
                pos_upd       = 2'd1;
            end
            2'd1:
            begin
                head_upd[15:8] = head_reg[15:8] | b;
                pos_upd        = 2'd2;
            end
            2'd2:
            begin
                head_upd[23:16] = head_reg[23:16] | b;
                pos_upd         = 2'd3;
            end
            default:
            begin
                head_upd = head_reg;
                pos_upd  = pos_reg;
            end
        endcase
    end

    always_comb
    begin
        pend_upd    = pend_reg;
        invalid_upd = invalid_reg;
        if (pend_reg != 2'd0)
        begin
            if (is_cont)
            begin
                pend_upd = pend_reg - 2'd1;
            end
            else
            begin
                invalid_upd = 1'b1;
                pend_upd    = 2'd0;
            end
        end
        else if (b[7])
        begin
            if (b[7:5] == 3'b110 && b >= tes_pkg::LEAD2_MIN)
            begin
                pend_upd = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                pend_upd = 2'd2;
            end
            else if (b[7:3] == 5'b11110 && b <= tes_pkg::LEAD4_MAX)
            begin
                pend_upd = 2'd3;
            end
            else
            begin
                invalid_upd = 1'b1;
            end
        end
    end

    assign h0 = head_upd[7:0];
    assign h1 = head_upd[15:8];
    assign h2 = head_upd[23:16];

    always_comb
    begin
        if (pos_upd == 2'd3 && h0 == tes_pkg::BOM8_B0 && h1 == tes_pkg::BOM8_B1
            && h2 == tes_pkg::BOM8_B2)
        begin
            result.encoding_class = tes_pkg::CLASS_UTF8_BOM;
            result.payload_offset = tes_pkg::OFFSET_UTF8_BOM;
        end
        else if (pos_upd >= 2'd2 && h0 == tes_pkg::BYTE_FF && h1 == tes_pkg::BYTE_FE)
        begin
            result.encoding_class = tes_pkg::CLASS_UTF16LE;
            result.payload_offset = tes_pkg::OFFSET_UTF16_BOM;
        end
        else if (pos_upd >= 2'd2 && h0 == tes_pkg::BYTE_FE && h1 == tes_pkg::BYTE_FF)
        begin
            result.encoding_class = tes_pkg::CLASS_UTF16BE;
            result.payload_offset = tes_pkg::OFFSET_UTF16_BOM;
        end
        else if (!invalid_upd && pend_upd == 2'd0)
        begin
            result.encoding_class = tes_pkg::CLASS_UTF8;
            result.payload_offset = tes_pkg::OFFSET_NONE;
        end
        else
        begin
            result.encoding_class = tes_pkg::CLASS_LEGACY;
            result.payload_offset = tes_pkg::OFFSET_NONE;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        head_next    = head_reg;
        pend_next    = pend_reg;
        invalid_next = invalid_reg;
        if (take)
        begin
            if (beat.last_byte)
            begin
                pos_next     = 2'd0;
                head_next    = 24'd0;
                pend_next    = 2'd0;
                invalid_next = 1'b0;
            end
            else
            begin
                pos_next     = pos_upd;
                head_next    = head_upd;
                pend_next    = pend_upd;
                invalid_next = invalid_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 2'd0;
            head_reg    <= 24'd0;
            pend_reg    <= 2'd0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            head_reg    <= head_next;
            pend_reg    <= pend_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tes_out_stage.sv
// Result register that holds one classification beat for the result channel.
`default_nettype none
module tes_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire tes_pkg::out_beat_t result,
    output logic                   free,
    tes_out_if.source              verdict
);

    logic               valid_reg;
    logic               valid_next;
    tes_pkg::out_beat_t result_reg;

    assign free       = !valid_reg || verdict.ready;
    assign valid_next = load || (valid_reg && !verdict.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign verdict.valid          = valid_reg;
    assign verdict.encoding_class = result_reg.encoding_class;
    assign verdict.payload_offset = result_reg.payload_offset;

endmodule
`default_nettype wire

FILE: rtl/core/text_encoding_sniffer_unit.sv
// Top level of the text encoding sniffer: input register, scan logic, result register.
// A last byte waits in the input register, then its result in the result register.
// Throughput: one byte beat per cycle; the result register holds a waiting beat
// while following bytes keep flowing, and only a further last byte waits for it.
// Reset: rst_n clears all document state and both valid flags at once.
`default_nettype none
module text_encoding_sniffer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tes_in_if.sink      doc,
    tes_out_if.source   verdict
);

    tes_pkg::stage_stat_t stat;
    tes_pkg::in_beat_t    beat;
    tes_pkg::out_beat_t   result;
    logic                 out_free;
    logic                 take;

    assign take = stat.valid && (!stat.last || out_free);

    tes_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .doc   (doc),
        .take  (take),
        .stat  (stat),
        .beat  (beat)
    );

    tes_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .beat   (beat),
        .result (result)
    );

    tes_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (take && stat.last),
        .result  (result),
        .free    (out_free),
        .verdict (verdict)
    );

endmodule
`default_nettype wire
